@@ rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the trie prefix count engine
// Request codes, table geometry, controller states and command/status structs.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int Nodes     = 4096;
  localparam int Alphabet  = 26;
  localparam int MaxLen    = 32;
  localparam int CountBits = 16;

  localparam int NodeW  = $clog2(Nodes);
  localparam int SymW   = 5;
  localparam int SlotW  = $clog2(Nodes * Alphabet);
  localparam int PathW  = $clog2(MaxLen);
  localparam int PlenW  = $clog2(MaxLen + 2);
  localparam int UsedW  = $clog2(Nodes + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_COUNT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DEL_READ,
    ST_DEL_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;   // write one zero into child table, and into count table while in range
    logic latch_item;   // capture incoming letter, read its child slot
    logic lookup;       // read count of the child node
    logic update;       // apply letter to the trie
    logic del_read;     // read count of path entry
    logic del_write;    // write decremented count, advance path index
    logic make_result;  // form result, reset walk state
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_last;
    logic del_go;       // delete pass needed at end of word
    logic del_done;     // path index reached path length
  } status_t;

  function automatic logic [SlotW-1:0] slot_of(input logic [NodeW-1:0] node,
                                               input logic [SymW-1:0] sym);
    logic [SlotW-1:0] prod;
    prod = SlotW'(node) * SlotW'(Alphabet);
    return prod + SlotW'(sym);
  endfunction

endpackage

@@ rtl/tpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpc_ctrl: sequencer of the trie prefix count engine
// Steps through clearing, per-letter lookup/update and the delete pass.
// ----------------------------------------------------------------------------
module tpc_ctrl
  import tpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    res_busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP:    state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!status.is_last) state_next = ST_IDLE;
        else if (status.del_go) state_next = ST_DEL_READ;
        else state_next = ST_RESULT;
      end
      ST_DEL_READ:  state_next = status.del_done ? ST_RESULT : ST_DEL_WRITE;
      ST_DEL_WRITE: state_next = ST_DEL_READ;
      ST_RESULT:    if (!res_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR:     cmd.clear_step = !status.clear_done;
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      ST_LOOKUP:    cmd.lookup = 1'b1;
      ST_UPDATE:    cmd.update = 1'b1;
      ST_DEL_READ:  cmd.del_read = !status.del_done;
      ST_DEL_WRITE: cmd.del_write = 1'b1;
      ST_RESULT:    cmd.make_result = !res_busy;
      default:      cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("input taken during clear");
  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_item |=> state == ST_LOOKUP) else $error("lookup not after accept");
  a_update_follows: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |=> cmd.update) else $error("update not after lookup");
`endif

endmodule

@@ rtl/tpc_datapath.sv @@
// ----------------------------------------------------------------------------
// tpc_datapath: trie storage and walk state
// Child table and count memories, cursor, path store, result register.
// ----------------------------------------------------------------------------
module tpc_datapath
  import tpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [1:0]           in_req,
  input  logic [SymW-1:0]      in_letter,
  input  logic                 in_last,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_found,
  output logic [15:0]          res_count,
  output logic                 res_full
);

  logic [NodeW-1:0]     child_mem [Nodes*Alphabet];
  logic [CountBits-1:0] count_mem [Nodes];
  logic [NodeW-1:0]     path_mem  [MaxLen];

  logic [SlotW-1:0]     clr_addr;
  logic                 clr_done;
  logic [1:0]           req;
  logic [SymW-1:0]      sym;
  logic                 last;
  logic [NodeW-1:0]     cursor;
  logic [UsedW-1:0]     nodes_used;
  logic [PlenW-1:0]     path_len;
  logic [PlenW-1:0]     del_idx;
  logic                 miss;
  logic [NodeW-1:0]     child_rd;
  logic [CountBits-1:0] cnt_rd;
  logic [NodeW-1:0]     path_rd;
  logic [NodeW-1:0]     del_node;
  logic [SlotW-1:0]     cur_slot;
  logic [SymW-1:0]      sym_sat;
  logic                 need_new;
  logic                 pool_out;
  logic [NodeW-1:0]     nxt;
  logic [CountBits-1:0] cnt_nxt;
  logic [CountBits-1:0] cnt_fin;

  // child read returns zero for a missing child, so a new node's count starts at one
  assign sym_sat  = (in_letter > SymW'(Alphabet - 1)) ? SymW'(Alphabet - 1) : in_letter;
  assign cur_slot = slot_of(cursor, sym);
  assign need_new = (child_rd == '0);
  assign pool_out = nodes_used >= UsedW'(Nodes);
  assign nxt      = need_new ? nodes_used[NodeW-1:0] : child_rd;
  assign cnt_nxt  = need_new ? CountBits'(1)
                  : (&cnt_rd) ? cnt_rd : cnt_rd + CountBits'(1);

  // clearing sweep of child and count tables
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + SlotW'(1);
      if (clr_addr == SlotW'(Nodes * Alphabet - 1)) clr_done <= 1'b1;
    end
  end

  // child slot is read on the accepting edge; the cursor is stable while idle
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      child_mem[clr_addr] <= '0;
    end else if (cmd.update && !miss && req == REQ_INSERT && need_new && !pool_out) begin
      child_mem[cur_slot] <= nodes_used[NodeW-1:0];
    end
    if (cmd.latch_item) child_rd <= child_mem[slot_of(cursor, sym_sat)];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && clr_addr < SlotW'(Nodes)) begin
      count_mem[clr_addr[NodeW-1:0]] <= '0;
    end else if (cmd.update && !miss && req == REQ_INSERT && !(need_new && pool_out)) begin
      count_mem[nxt] <= cnt_nxt;
    end else if (cmd.del_write && cnt_rd != '0) begin
      count_mem[del_node] <= cnt_rd - CountBits'(1);
    end
    if (cmd.lookup) cnt_rd <= count_mem[child_rd];
    else if (cmd.del_read) cnt_rd <= count_mem[path_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !miss && req != REQ_INSERT && !(need_new || cnt_rd == '0)
        && path_len < PlenW'(MaxLen))
      path_mem[path_len[PathW-1:0]] <= child_rd;
    if (cmd.del_read) begin
      del_node <= path_rd;
    end
  end
  assign path_rd = path_mem[del_idx[PathW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      req  <= in_req;
      sym  <= sym_sat;
      last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      nodes_used <= UsedW'(1);
      path_len   <= '0;
      miss       <= 1'b0;
      del_idx    <= '0;
      res_valid  <= 1'b0;
      res_found  <= 1'b0;
      res_count  <= '0;
      res_full   <= 1'b0;
    end else begin
      if (cmd.make_result) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.update && !miss) begin
        if (req == REQ_INSERT) begin
          if (need_new && pool_out) begin
            miss <= 1'b1;
          end else begin
            cursor <= nxt;
            if (need_new) nodes_used <= nodes_used + UsedW'(1);
          end
        end else if (need_new || cnt_rd == '0) begin
          miss <= 1'b1;
        end else begin
          cursor <= child_rd;
          if (path_len <= PlenW'(MaxLen)) path_len <= path_len + PlenW'(1);
        end
      end
      if (cmd.del_write) del_idx <= del_idx + PlenW'(1);
      if (cmd.make_result) begin
        res_found <= !miss && (req != REQ_DELETE || path_len <= PlenW'(MaxLen));
        res_full  <= miss && req == REQ_INSERT;
        res_count <= (!miss && req == REQ_COUNT) ? 16'(cnt_fin) : '0;
        cursor    <= '0;
        path_len  <= '0;
        miss      <= 1'b0;
        del_idx   <= '0;
      end
    end
  end

  // final node count: kept from the last update of the word
  always_ff @(posedge clk) begin
    if (cmd.update) cnt_fin <= cnt_rd;
  end

  assign status.clear_done = clr_done;
  assign status.is_last    = last;
  assign status.del_go     = (req == REQ_DELETE) && !(miss || (!miss && (need_new || cnt_rd == '0)))
                             && path_len < PlenW'(MaxLen);
  assign status.del_done   = del_idx >= path_len;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= UsedW'(Nodes)) else $error("node pool overrun");
  a_path_bound: assert property (@(posedge clk) disable iff (rst)
    path_len <= PlenW'(MaxLen + 1)) else $error("path length overrun");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    cmd.make_result |=> res_valid) else $error("result not raised");
`endif

endmodule

@@ rtl/trie_prefix_count_engine_unit.sv @@
// ----------------------------------------------------------------------------
// trie_prefix_count_engine_unit: trie of lowercase words with prefix counts
// Top level joining the sequencer and the trie datapath.
// ----------------------------------------------------------------------------
// Usage: words enter one letter per transfer on s_axis. tdata holds
// req_type [1:0] and letter [6:2]; tlast marks the last letter. One result
// leaves on m_axis for each word, after its last letter.
// Each letter passes accept with child read, count read and update in
// turn; no new letter is taken until its update is done. A word ends
// with a result step; a delete word first adds a count decrement pass
// that reads and then writes the count of each path node. The result is
// registered in the result step, after the last letter's update (after
// the delete pass for a delete word); the block waits in its result step
// while an earlier result has not been taken.
// Reset starts a clearing pass over all 106496 child table slots (and the
// count table alongside); no letter is accepted until it is done.
// A stalled receiver holds the result and blocks the next word's end.
// ----------------------------------------------------------------------------
module trie_prefix_count_engine_unit
  import tpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // req_type[1:0], letter[6:2], zero[7]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // found[0], prefix_count[16:1], pool_full[17]
);
  cmd_t    cmd;
  status_t status;
  logic    found, full;
  logic [15:0] cnt;

  tpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .res_busy(m_axis_tvalid && !m_axis_tready), .status(status), .cmd(cmd)
  );

  tpc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_req(s_axis_tdata[1:0]), .in_letter(s_axis_tdata[6:2]), .in_last(s_axis_tlast),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_found(found), .res_count(cnt), .res_full(full)
  );

  assign m_axis_tdata = {6'd0, full, cnt, found};

endmodule
